// ----- rtl/core/sorted_priority_list_assert.svh -----
// assertion macros shared by the checker
`ifndef SORTED_PRIORITY_LIST_ASSERT_SVH
`define SORTED_PRIORITY_LIST_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SPL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_priority_list check failed");

// next-cycle implication
`define SPL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_priority_list check failed");

`endif

// ----- rtl/core/spl_pkg.sv -----
package spl_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int FUNC_W   = 2;
	localparam int ID_W     = 32;
	localparam int RANK_W   = 2;
	localparam int AMOUNT_W = 24;
	localparam int POINTS_W = 24;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 5;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

	// cell load selection
	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_NEW   = 2'd1;
	localparam logic [1:0] CELL_LEFT  = 2'd2;
	localparam logic [1:0] CELL_RIGHT = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [RANK_W-1:0]   rank;
		logic [AMOUNT_W-1:0] amount;
		logic [POINTS_W-1:0] points;
	} entry_t;

	typedef struct packed {
		logic [1:0] op;
	} cell_ctl_t;

	typedef struct packed {
		logic valid;
		logic ge;     // empty, or the key ranks strictly ahead of this entry
		logic match;  // holds an entry with the key's id
	} cell_stat_t;

endpackage

// ----- rtl/core/spl_cell.sv -----
module spl_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spl_pkg::cell_ctl_t ctl,
	input  spl_pkg::entry_t    key,
	input  spl_pkg::entry_t    left_entry,
	input  logic               left_valid,
	input  spl_pkg::entry_t    right_entry,
	input  logic               right_valid,
	output spl_pkg::entry_t    entry,
	output spl_pkg::cell_stat_t stat
);

	spl_pkg::entry_t entry_q;
	logic            valid_q;
	logic            ahead;

	// key ranks strictly ahead: smaller rank, then larger amount, then larger points
	always_comb begin
		if (key.rank != entry_q.rank) begin
			ahead = key.rank < entry_q.rank;
		end else if (key.amount != entry_q.amount) begin
			ahead = key.amount > entry_q.amount;
		end else begin
			ahead = key.points > entry_q.points;
		end
	end

	assign stat.valid = valid_q;
	assign stat.ge    = !valid_q || ahead;
	assign stat.match = valid_q && (key.id == entry_q.id);
	assign entry      = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				spl_pkg::CELL_NEW:   valid_q <= 1'b1;
				spl_pkg::CELL_LEFT:  valid_q <= left_valid;
				spl_pkg::CELL_RIGHT: valid_q <= right_valid;
				default:             valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			spl_pkg::CELL_NEW:   entry_q <= key;
			spl_pkg::CELL_LEFT:  entry_q <= left_entry;
			spl_pkg::CELL_RIGHT: entry_q <= right_entry;
			default:             entry_q <= entry_q;
		endcase
	end

endmodule

// ----- rtl/core/sorted_priority_list.sv -----
// sorted priority list: a row of DEPTH cells, best entry in cell 0
// insert and delete: the item runs in ST_EXEC and its result is registered; busy holds off a new item meanwhile
// dump: results are registered from ST_DUMP, one per cycle
// dump: busy until the token reaches the last held entry or the list is found empty; no new item meanwhile
// an unused func code passes through ST_EXEC and gives no result
// results are shown for one cycle on strobe; the receiver cannot stall them
// arst_n clears every cell's valid bit and the control state; the list starts empty
module sorted_priority_list #(
	parameter int DEPTH = spl_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [spl_pkg::FUNC_W-1:0]    func,
	input  logic [spl_pkg::ID_W-1:0]      customer_id,
	input  logic [spl_pkg::RANK_W-1:0]    rank,
	input  logic [spl_pkg::AMOUNT_W-1:0]  amount,
	input  logic [spl_pkg::POINTS_W-1:0]  points,
	output logic                          strobe,
	output logic [spl_pkg::STATUS_W-1:0]  status,
	output logic [spl_pkg::POS_W-1:0]     position,
	output logic [spl_pkg::ID_W-1:0]      out_id,
	output logic [spl_pkg::RANK_W-1:0]    out_rank,
	output logic [spl_pkg::AMOUNT_W-1:0]  out_amount,
	output logic [spl_pkg::POINTS_W-1:0]  out_points,
	output logic                          last
);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DUMP = 2'd2;

	logic [1:0]                    state_q;
	logic [spl_pkg::FUNC_W-1:0]    func_q;
	spl_pkg::entry_t               key_q;

	// dump token walks the row one cell a cycle
	logic [DEPTH-1:0]              tok_q;
	logic [spl_pkg::POS_W-1:0]     dpos_q;

	// per-cell wiring
	spl_pkg::entry_t               cell_entry [DEPTH];
	spl_pkg::cell_stat_t           cell_stat  [DEPTH];
	spl_pkg::cell_ctl_t            cell_ctl   [DEPTH];
	spl_pkg::entry_t               left_entry [DEPTH];
	spl_pkg::entry_t               right_entry[DEPTH];
	logic [DEPTH-1:0]              left_valid;
	logic [DEPTH-1:0]              right_valid;

	logic [DEPTH-1:0]              ge_v;
	logic [DEPTH-1:0]              seen_v;   // a matching id at or before this cell
	logic [DEPTH-1:0]              first_v;  // first matching cell, one-hot
	logic [DEPTH-1:0]              here_v;   // insertion cell, one-hot
	logic                          full;
	logic                          empty;
	logic                          found;

	spl_pkg::entry_t               del_entry;
	spl_pkg::entry_t               dump_entry;
	logic                          dump_last;
	logic [spl_pkg::POS_W-1:0]     ins_pos;
	logic [spl_pkg::POS_W-1:0]     del_pos;

	// registered result
	logic                          strobe_q;
	logic [spl_pkg::STATUS_W-1:0]  status_q;
	logic [spl_pkg::POS_W-1:0]     pos_q;
	spl_pkg::entry_t               res_q;
	logic                          last_q;

	logic                          nxt_strobe;
	logic [spl_pkg::STATUS_W-1:0]  nxt_status;
	logic [spl_pkg::POS_W-1:0]     nxt_pos;
	spl_pkg::entry_t               nxt_res;
	logic                          nxt_last;

	logic                          do_insert;
	logic                          do_delete;

	// neighbour links; the ends of the row see an empty cell
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0) begin
				left_entry[i] = '0;
				left_valid[i] = 1'b0;
			end else begin
				left_entry[i] = cell_entry[i-1];
				left_valid[i] = cell_stat[i-1].valid;
			end
			if (i == DEPTH-1) begin
				right_entry[i] = '0;
				right_valid[i] = 1'b0;
			end else begin
				right_entry[i] = cell_entry[i+1];
				right_valid[i] = cell_stat[i+1].valid;
			end
			ge_v[i] = cell_stat[i].ge;
		end
	end

	assign full  = cell_stat[DEPTH-1].valid;
	assign empty = !cell_stat[0].valid;

	assign do_insert = (state_q == ST_EXEC) && (func_q == spl_pkg::FUNC_INSERT) && !full;
	assign do_delete = (state_q == ST_EXEC) && (func_q == spl_pkg::FUNC_DELETE);

	// valid entries form a prefix and are sorted, so ge_v is a thermometer:
	// the first set bit is where the new item goes, every cell after it shifts back
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			here_v[i]  = ge_v[i] && ((i == 0) ? 1'b1 : !ge_v[(i == 0) ? 0 : i-1]);
			first_v[i] = cell_stat[i].match && !seen;
			seen       = seen || cell_stat[i].match;
			seen_v[i]  = seen;
		end
	end

	assign found = seen_v[DEPTH-1];

	// cell load selection
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].op = spl_pkg::CELL_HOLD;
			if (do_insert) begin
				if (here_v[i]) begin
					cell_ctl[i].op = spl_pkg::CELL_NEW;
				end else if (ge_v[i]) begin
					cell_ctl[i].op = spl_pkg::CELL_LEFT;
				end
			end else if (do_delete && seen_v[i]) begin
				// close the gap: everything from the removed entry on moves forward
				cell_ctl[i].op = spl_pkg::CELL_RIGHT;
			end
		end
	end

	// one-hot selects onto the result
	always_comb begin
		del_entry  = '0;
		dump_entry = '0;
		dump_last  = 1'b0;
		ins_pos    = '0;
		del_pos    = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_v[i]) begin
				del_entry = del_entry | cell_entry[i];
				del_pos   = del_pos | spl_pkg::POS_W'(i + 1);
			end
			if (here_v[i]) begin
				ins_pos = ins_pos | spl_pkg::POS_W'(i + 1);
			end
			if (tok_q[i]) begin
				dump_entry = dump_entry | cell_entry[i];
				dump_last  = dump_last | !right_valid[i];
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		spl_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (cell_ctl[g]),
			.key         (key_q),
			.left_entry  (left_entry[g]),
			.left_valid  (left_valid[g]),
			.right_entry (right_entry[g]),
			.right_valid (right_valid[g]),
			.entry       (cell_entry[g]),
			.stat        (cell_stat[g])
		);
	end

	// result selection for the current cycle
	always_comb begin
		nxt_strobe = 1'b0;
		nxt_status = spl_pkg::STAT_OK;
		nxt_pos    = '0;
		nxt_res    = key_q;
		nxt_last   = 1'b1;
		unique case (state_q)
			ST_EXEC: begin
				case (func_q)
					spl_pkg::FUNC_INSERT: begin
						nxt_strobe = 1'b1;
						if (full) begin
							nxt_status = spl_pkg::STAT_FULL;
						end else begin
							nxt_pos = ins_pos;
						end
					end
					spl_pkg::FUNC_DELETE: begin
						nxt_strobe = 1'b1;
						if (found) begin
							nxt_pos = del_pos;
							nxt_res = del_entry;
						end else begin
							// not found: echo the id, clear the rest
							nxt_status = spl_pkg::STAT_NOTFOUND;
							nxt_res    = '0;
							nxt_res.id = key_q.id;
						end
					end
					default: begin
						nxt_strobe = 1'b0;
					end
				endcase
			end
			ST_DUMP: begin
				nxt_strobe = 1'b1;
				if (empty) begin
					nxt_status = spl_pkg::STAT_EMPTY;
					nxt_res    = '0;
				end else begin
					nxt_pos  = dpos_q;
					nxt_res  = dump_entry;
					nxt_last = dump_last;
				end
			end
			default: begin
				nxt_strobe = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			tok_q    <= '0;
			dpos_q   <= '0;
		end else begin
			strobe_q <= nxt_strobe;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (func == spl_pkg::FUNC_DUMP) begin
							state_q <= ST_DUMP;
							tok_q   <= DEPTH'(1);
							dpos_q  <= spl_pkg::POS_W'(1);
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				ST_DUMP: begin
					tok_q  <= tok_q << 1;
					dpos_q <= dpos_q + spl_pkg::POS_W'(1);
					if (empty || dump_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture and result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			func_q        <= func;
			key_q.id      <= customer_id;
			key_q.rank    <= rank;
			key_q.amount  <= amount;
			key_q.points  <= points;
		end
		status_q <= nxt_status;
		pos_q    <= nxt_pos;
		res_q    <= nxt_res;
		last_q   <= nxt_last;
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign status     = status_q;
	assign position   = pos_q;
	assign out_id     = res_q.id;
	assign out_rank   = res_q.rank;
	assign out_amount = res_q.amount;
	assign out_points = res_q.points;
	assign last       = last_q;

endmodule

// ----- rtl/core/spl_checker.sv -----
`include "sorted_priority_list_assert.svh"

module spl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          strobe,
	input logic [spl_pkg::STATUS_W-1:0]  status,
	input logic [spl_pkg::POS_W-1:0]     position,
	input logic [spl_pkg::ID_W-1:0]      out_id,
	input logic                          last
);

	// an accepted item always occupies the block for the following cycle
	`SPL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

	// a dump streams without gaps until its final result
	`SPL_ASSERT_NEXT(a_dump_streams, strobe && !last, strobe)

	// error and empty reports are single results
	`SPL_ASSERT_NOW(a_err_last, strobe && (status != spl_pkg::STAT_OK), last)

	// an empty list reports nothing held
	`SPL_ASSERT_NOW(a_empty_zero, strobe && (status == spl_pkg::STAT_EMPTY),
		(position == '0) && (out_id == '0))

endmodule

bind sorted_priority_list spl_checker u_spl_checker (.*);

// ----- bench/tb_sorted_priority_list.sv -----
module tb_sorted_priority_list;
	timeunit 1ns;
	timeprecision 1ps;

	import spl_pkg::*;

	localparam int DEPTH = DEPTH_DEF;

	// the one func code with no meaning, sent to check it is ignored
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	// cycles to let the block settle once nothing is expected:
	// a full dump keeps it busy until the token has passed every cell
	localparam int SETTLE_CYCLES = DEPTH + 8;

	// cycles with no item and no result taken before giving up
	localparam int STALL_LIMIT = 400;

	localparam int REPORT_LIMIT = 10;

	// one expected result, laid out like the result ports
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		entry_t              ent;
		logic                last;
	} list_result_t;

	// clock, reset and stimulus side, all known from time zero
	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic [FUNC_W-1:0]   func         = FUNC_DUMP;
	logic [ID_W-1:0]     customer_id  = '0;
	logic [RANK_W-1:0]   rank         = '0;
	logic [AMOUNT_W-1:0] amount       = '0;
	logic [POINTS_W-1:0] points       = '0;

	// result side
	logic                busy;
	logic                strobe;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    position;
	logic [ID_W-1:0]     out_id;
	logic [RANK_W-1:0]   out_rank;
	logic [AMOUNT_W-1:0] out_amount;
	logic [POINTS_W-1:0] out_points;
	logic                last;

	// our own copy of the list, best entry first
	entry_t       list_model [DEPTH];
	int           list_fill;
	list_result_t expected_results [$];

	// run bookkeeping
	int  fail_count = 0;
	int  stall_cycles = 0;
	bit  sender_idles;
	int  items_sent;
	int  results_checked;
	int  inserts_sent;
	int  full_drops;
	int  deletes_sent;
	int  delete_misses;
	int  dumps_sent;
	int  empty_dumps;
	int  unused_sent;
	int  deepest_fill;

	sorted_priority_list #(
		.DEPTH(DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.customer_id (customer_id),
		.rank        (rank),
		.amount      (amount),
		.points      (points),
		.strobe      (strobe),
		.status      (status),
		.position    (position),
		.out_id      (out_id),
		.out_rank    (out_rank),
		.out_amount  (out_amount),
		.out_points  (out_points),
		.last        (last)
	);

	always #5 clk = ~clk;

	// count a failure, print only the first few
	task automatic note_failure(string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("[%0t] mismatch %0d: %s", $realtime, fail_count, what);
		end
	endtask

	// work out what the list does with one accepted item and queue its results
	function automatic void predict_list_op(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id,
			logic [RANK_W-1:0] rk, logic [AMOUNT_W-1:0] am, logic [POINTS_W-1:0] pt);
		int     p;
		int     i;
		entry_t fresh;
		fresh = '{id: id, rank: rk, amount: am, points: pt};
		case (op)
		FUNC_INSERT: begin
			inserts_sent++;
			if (list_fill >= DEPTH) begin
				// no room: item echoed back, list untouched
				full_drops++;
				expected_results.push_back({STAT_FULL, POS_W'(0), fresh, 1'b1});
			end else begin
				// first held entry the new key beats strictly; equal keys queue behind
				p = list_fill;
				for (i = 0; i < list_fill; i++) begin
					if (rk != list_model[i].rank) begin
						if (rk < list_model[i].rank) begin
							p = i;
							break;
						end
					end else if (am != list_model[i].amount) begin
						if (am > list_model[i].amount) begin
							p = i;
							break;
						end
					end else if (pt > list_model[i].points) begin
						p = i;
						break;
					end
				end
				for (i = list_fill; i > p; i--) begin
					list_model[i] = list_model[i - 1];
				end
				list_model[p] = fresh;
				list_fill++;
				if (list_fill > deepest_fill) begin
					deepest_fill = list_fill;
				end
				expected_results.push_back({STAT_OK, POS_W'(p + 1), fresh, 1'b1});
			end
		end
		FUNC_DELETE: begin
			deletes_sent++;
			// only the first match in priority order goes
			p = list_fill;
			for (i = 0; i < list_fill; i++) begin
				if (list_model[i].id == id) begin
					p = i;
					break;
				end
			end
			if (p == list_fill) begin
				delete_misses++;
				fresh = '{id: id, rank: '0, amount: '0, points: '0};
				expected_results.push_back({STAT_NOTFOUND, POS_W'(0), fresh, 1'b1});
			end else begin
				expected_results.push_back({STAT_OK, POS_W'(p + 1), list_model[p], 1'b1});
				for (i = p; i + 1 < list_fill; i++) begin
					list_model[i] = list_model[i + 1];
				end
				list_fill--;
			end
		end
		FUNC_DUMP: begin
			dumps_sent++;
			if (list_fill == 0) begin
				empty_dumps++;
				expected_results.push_back({STAT_EMPTY, POS_W'(0), entry_t'('0), 1'b1});
			end else begin
				for (i = 0; i < list_fill; i++) begin
					expected_results.push_back({STAT_OK, POS_W'(i + 1), list_model[i],
						1'(i + 1 == list_fill)});
				end
			end
		end
		default: begin
			// unused code: no result, no change
			unused_sent++;
		end
		endcase
	endfunction

	// drive one item and hold it until the block takes it; start stays high afterwards
	task automatic send_item(logic [FUNC_W-1:0] op, logic [ID_W-1:0] id,
			logic [RANK_W-1:0] rk, logic [AMOUNT_W-1:0] am, logic [POINTS_W-1:0] pt);
		func         <= op;
		customer_id  <= id;
		rank         <= rk;
		amount       <= am;
		points       <= pt;
		start        <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0) begin
			@(posedge clk);
		end
		predict_list_op(op, id, rk, am, pt);
		items_sent++;
	endtask

	// random gap between items: mostly none or short, now and then long
	task automatic pause_sender();
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (!sender_idles || roll < 55) begin
			gap = 0;
		end else if (roll < 90) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender off until every queued result is in, then let the block settle
	task automatic wait_for_results();
		start <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// key field with plenty of ties and both extremes
	function automatic logic [AMOUNT_W-1:0] pick_key_value();
		case ($urandom_range(0, 9))
		0: begin
			return '0;
		end
		1: begin
			return '1;
		end
		2, 3, 4: begin
			return AMOUNT_W'($urandom_range(1, 3));
		end
		default: begin
			return AMOUNT_W'($urandom);
		end
		endcase
	endfunction

	// one random item with the given operation mix in percent, the rest unused codes
	task automatic send_random_item(int insert_pct, int delete_pct, int dump_pct);
		int                  roll;
		logic [FUNC_W-1:0]   op;
		logic [ID_W-1:0]     id;
		logic [RANK_W-1:0]   rk;
		roll = $urandom_range(0, 99);
		if (roll < insert_pct) begin
			op = FUNC_INSERT;
		end else if (roll < insert_pct + delete_pct) begin
			op = FUNC_DELETE;
		end else if (roll < insert_pct + delete_pct + dump_pct) begin
			op = FUNC_DUMP;
		end else begin
			op = FUNC_UNUSED;
		end
		// deletes mostly aim at a held id, inserts now and then reuse one
		id = $urandom;
		if (list_fill > 0) begin
			if ((op == FUNC_DELETE && $urandom_range(0, 9) != 0) ||
					(op == FUNC_INSERT && $urandom_range(0, 7) == 0)) begin
				id = list_model[$urandom_range(0, list_fill - 1)].id;
			end
		end
		// rank zero is outside the usual classes but must sort first
		rk = ($urandom_range(0, 9) == 0) ? RANK_W'(0) : RANK_W'($urandom_range(1, 3));
		send_item(op, id, rk, pick_key_value(), POINTS_W'(pick_key_value()));
		pause_sender();
	endtask

	// empty list: dump and delete report the empty and missing cases, unused code is dropped
	task automatic test_empty_list();
		sender_idles = 1'b1;
		send_item(FUNC_DUMP, 32'h0, 2'd1, '0, '0);
		pause_sender();
		send_item(FUNC_DELETE, 32'hFFFF_FFFF, 2'd1, '0, '0);
		pause_sender();
		send_item(FUNC_UNUSED, 32'h1234_5678, 2'd3, '1, '1);
		pause_sender();
	endtask

	// each key field decides on its own, ties go behind, duplicate ids delete first in order
	task automatic test_key_ordering();
		send_item(FUNC_INSERT, 32'hFFFF_FFFF, 2'd3, '0, '0);
		pause_sender();
		send_item(FUNC_INSERT, 32'h0000_0000, 2'd1, '1, '1);
		pause_sender();
		send_item(FUNC_INSERT, 32'h0000_0001, 2'd1, '1, '1);      // full tie, goes behind
		pause_sender();
		send_item(FUNC_INSERT, 32'h0000_0002, 2'd0, '0, '0);      // rank zero goes first
		pause_sender();
		send_item(FUNC_INSERT, 32'h0000_0003, 2'd2, 24'd100, 24'd5);
		pause_sender();
		send_item(FUNC_INSERT, 32'h0000_0004, 2'd2, 24'd100, 24'd6); // points decide
		pause_sender();
		send_item(FUNC_INSERT, 32'h0000_0005, 2'd2, 24'd101, 24'd0); // amount decides
		pause_sender();
		send_item(FUNC_INSERT, 32'h0000_0001, 2'd3, '1, '0);      // duplicate id further back
		pause_sender();
		send_item(FUNC_DUMP, 32'h0, 2'd1, '0, '0);
		pause_sender();
		send_item(FUNC_DELETE, 32'h0000_0001, 2'd1, '0, '0);
		pause_sender();
		send_item(FUNC_DELETE, 32'hFFFF_FFFF, 2'd1, '0, '0);      // tail entry
		pause_sender();
		send_item(FUNC_DELETE, 32'h0000_0002, 2'd1, '0, '0);      // head entry
		pause_sender();
		send_item(FUNC_DELETE, 32'hDEAD_BEEF, 2'd1, '0, '0);      // not held
		pause_sender();
		send_item(FUNC_DUMP, 32'h0, 2'd1, '0, '0);
		pause_sender();
	endtask

	// alternate insert-heavy and delete-heavy stretches so the list fills, overflows and empties
	task automatic test_fill_and_drain();
		int phase;
		int k;
		for (phase = 0; phase < 8; phase++) begin
			// every third stretch runs back to back with no gaps
			sender_idles = (phase % 3 != 2);
			for (k = 0; k < 31; k++) begin
				if (phase % 2 == 0) begin
					send_random_item(75, 10, 10);
				end else begin
					send_random_item(15, 70, 10);
				end
			end
		end
	endtask

	// sender drained first, then a mix of all operations, unused codes included
	task automatic test_balanced_traffic();
		int k;
		wait_for_results();
		sender_idles = 1'b1;
		for (k = 0; k < 60; k++) begin
			send_random_item(45, 35, 15);
		end
	endtask

	// results are taken on the strobe and matched against the oldest expectation
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (expected_results.size() == 0) begin
				note_failure($sformatf("result with none expected: st=%0d pos=%0d id=%h last=%b",
					status, position, out_id, last));
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (status !== want.status || position !== want.position ||
						out_id !== want.ent.id || out_rank !== want.ent.rank ||
						out_amount !== want.ent.amount || out_points !== want.ent.points ||
						last !== want.last) begin
					note_failure($sformatf({"want st=%0d pos=%0d id=%h rk=%0d am=%h pt=%h last=%b",
						" | got st=%0d pos=%0d id=%h rk=%0d am=%h pt=%h last=%b"},
						want.status, want.position, want.ent.id, want.ent.rank,
						want.ent.amount, want.ent.points, want.last,
						status, position, out_id, out_rank, out_amount, out_points, last));
				end
			end
		end
	end

	// watchdog: a long stretch with neither an item nor a result taken means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && busy === 1'b0) || strobe === 1'b1) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
					STALL_LIMIT, expected_results.size());
				$display("tb_sorted_priority_list: FAIL");
				$finish;
			end
		end
	end

	initial begin
		list_fill = 0;
		sender_idles = 1'b1;

		// reset held from time zero, released on a clock edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_key_ordering();
		test_fill_and_drain();
		test_balanced_traffic();
		wait_for_results();

		$display("sent %0d items: %0d inserts (%0d refused as full), %0d deletes (%0d missed),",
			items_sent, inserts_sent, full_drops, deletes_sent, delete_misses);
		$display("%0d dumps (%0d of an empty list), %0d unused codes;",
			dumps_sent, empty_dumps, unused_sent);
		$display("%0d results checked, fill up to %0d", results_checked, deepest_fill);
		if (fail_count == 0) begin
			$display("tb_sorted_priority_list: PASS");
		end else begin
			$display("%0d mismatches in total", fail_count);
			$display("tb_sorted_priority_list: FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/spl_pkg.sv
rtl/core/spl_cell.sv
rtl/core/sorted_priority_list.sv
rtl/core/spl_checker.sv
bench/tb_sorted_priority_list.sv
